/* hw/rtl/pgs_pkg.sv */
`timescale 1ns / 1ps

package pgs_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 11;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [POS_W-1:0]   position;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

/* hw/rtl/pgs_req_if.sv */
`timescale 1ns / 1ps

interface pgs_req_if;
    logic                              valid;
    logic                              ready;
    logic signed [pgs_pkg::VALUE_W-1:0] value;
    logic                              first_of_sequence;

    modport source (output valid, output value, output first_of_sequence, input ready);
    modport sink   (input valid, input value, input first_of_sequence, output ready);
endinterface

/* hw/rtl/pgs_res_if.sv */
`timescale 1ns / 1ps

interface pgs_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [pgs_pkg::POS_W-1:0]   position;
    logic                        overflow;

    modport source (output valid, output found, output position, output overflow, input ready);
    modport sink   (input valid, input found, input position, input overflow, output ready);
endinterface

/* hw/rtl/pgs_cell.sv */
`timescale 1ns / 1ps

module pgs_cell (
    input  logic            clk,
    input  pgs_pkg::shift_t shift,
    input  pgs_pkg::entry_t upper,
    input  pgs_pkg::entry_t lower,
    output pgs_pkg::entry_t entry
);

    pgs_pkg::entry_t entry_reg;
    pgs_pkg::entry_t entry_next;

    always_comb
    begin
        priority if (shift.push)
        begin
            entry_next = upper;
        end
        else if (shift.pop)
        begin
            entry_next = lower;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/pgs_ctrl.sv */
`timescale 1ns / 1ps

module pgs_ctrl #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    pgs_req_if.sink         request,
    pgs_res_if.source       result,
    input  pgs_pkg::entry_t top,
    output pgs_pkg::entry_t push_entry,
    output pgs_pkg::shift_t shift
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    state_t                              state_reg, state_next;
    logic [CNT_W-1:0]                    stack_count_reg, stack_count_next;
    logic [CNT_W-1:0]                    item_count_reg, item_count_next;
    logic signed [pgs_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic                                res_valid_reg, res_valid_next;
    logic                                found_reg, found_next;
    logic [pgs_pkg::POS_W-1:0]           position_reg, position_next;
    logic                                overflow_reg, overflow_next;

    logic top_valid;
    logic slot_free;
    logic seq_full;

    assign top_valid = (stack_count_reg != '0);
    assign slot_free = !res_valid_reg || result.ready;
    assign seq_full  = (item_count_reg >= CNT_W'(MAX_ITEMS));

    assign request.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        stack_count_next = stack_count_reg;
        item_count_next  = item_count_reg;
        value_next       = value_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        found_next       = found_reg;
        position_next    = position_reg;
        overflow_next    = overflow_reg;
        shift            = '0;
        push_entry.value    = value_reg;
        push_entry.position = pgs_pkg::POS_W'(item_count_reg + 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    value_next = request.value;
                    if (request.first_of_sequence)
                    begin
                        stack_count_next = '0;
                        item_count_next  = '0;
                    end
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (seq_full)
                begin
                    if (slot_free)
                    begin
                        res_valid_next = 1'b1;
                        found_next     = 1'b0;
                        position_next  = '0;
                        overflow_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (top_valid && (top.value <= value_reg))
                begin
                    // drop a candidate that is not strictly greater
                    shift.pop        = 1'b1;
                    stack_count_next = stack_count_reg - 1'b1;
                end
                else
                begin
                    if (slot_free)
                    begin
                        res_valid_next   = 1'b1;
                        found_next       = top_valid;
                        position_next    = top_valid ? top.position : '0;
                        overflow_next    = 1'b0;
                        shift.push       = 1'b1;
                        stack_count_next = stack_count_reg + 1'b1;
                        item_count_next  = item_count_reg + 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            stack_count_reg <= '0;
            item_count_reg  <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stack_count_reg <= stack_count_next;
            item_count_reg  <= item_count_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        overflow_reg <= overflow_next;
    end

    assign result.valid    = res_valid_reg;
    assign result.found    = found_reg;
    assign result.position = position_reg;
    assign result.overflow = overflow_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        stack_count_reg <= item_count_reg)
        else $error("candidate count exceeds item count");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond sequence limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && overflow_reg |-> !found_reg && (position_reg == '0))
        else $error("overflow item reports a match");

    assert property (@(posedge clk) disable iff (!rst_n)
        shift.push |=> item_count_reg == CNT_W'($past(item_count_reg) + 1'b1))
        else $error("push without item count advance");
`endif

endmodule

/* hw/rtl/previous_greater_search.sv */
`timescale 1ns / 1ps

// Previous greater element search over a stream of signed 32-bit values.
// Channel request: valid/ready with value and first_of_sequence; an item is
// taken when valid and ready are both high. first_of_sequence starts a new
// sequence at that item.
// Channel result: valid/ready with found, position (1-based, 0 if none) and
// overflow, one result item per request item, in order.
// Candidates sit in a chain of MAX_ITEMS cells, top of stack in the first
// cell; cells shift down on a push and up on a pop, one step per cycle.
// After acceptance the search pops the candidates that are not strictly
// greater than the item, one pop per cycle in the chain, then pushes the
// item and registers its result. The next item is taken only after that,
// once the controller is back in idle; each stored item is pushed once and
// popped at most once.
// Items beyond MAX_ITEMS in one sequence report overflow and are not stored.
// Reset empties the stack and the sequence; no clearing pass is needed.
// While the receiver stalls, the result is held; the next request item is
// still taken and searched, and waits only when its own result is ready.
module previous_greater_search #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    pgs_req_if.sink   request,
    pgs_res_if.source result
);

    pgs_pkg::entry_t entries [MAX_ITEMS+1];
    pgs_pkg::entry_t push_entry;
    pgs_pkg::shift_t shift;

    pgs_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .result     (result),
        .top        (entries[0]),
        .push_entry (push_entry),
        .shift      (shift)
    );

    assign entries[MAX_ITEMS] = '0;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        pgs_cell u_cell (
            .clk   (clk),
            .shift (shift),
            .upper ((i == 0) ? push_entry : entries[(i == 0) ? 0 : i - 1]),
            .lower (entries[i+1]),
            .entry (entries[i])
        );
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_W = pgs_pkg::VALUE_W;
    localparam int POS_W   = pgs_pkg::POS_W;

    localparam int SEQ_LIMIT     = 1024;
    localparam int RANDOM_ITEMS  = 100;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DIRECTED_ROWS = 23;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } answer_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      first;
        logic                      typed;
        answer_t                   answer;
    } vector_t;

    typedef enum int {
        NEAR_ZERO,
        ANY_VALUE,
        FALLING,
        EXTREME
    } value_mode_t;

    localparam vector_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'sd5,      1'b0, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{32'sd3,      1'b0, 1'b1, '{1'b1, 11'd1, 1'b0}},
        '{32'sd3,      1'b0, 1'b1, '{1'b1, 11'd1, 1'b0}},
        '{32'sd4,      1'b0, 1'b1, '{1'b1, 11'd1, 1'b0}},
        '{32'sd5,      1'b0, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{VALUE_MAX,   1'b1, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{VALUE_MIN,   1'b0, 1'b1, '{1'b1, 11'd1, 1'b0}},
        '{-32'sd1,     1'b0, 1'b1, '{1'b1, 11'd1, 1'b0}},
        '{32'sd0,      1'b0, 1'b1, '{1'b1, 11'd1, 1'b0}},
        '{VALUE_MAX,   1'b0, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{VALUE_MIN,   1'b1, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{VALUE_MIN,   1'b0, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{32'sd1,      1'b0, 1'b0, '0},
        '{-32'sd1,     1'b0, 1'b0, '0},
        '{32'sd100,    1'b1, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{32'sd50,     1'b0, 1'b0, '0},
        '{32'sd75,     1'b0, 1'b0, '0},
        '{32'sd60,     1'b0, 1'b0, '0},
        '{32'sd200,    1'b0, 1'b0, '0},
        '{32'sd10,     1'b0, 1'b0, '0},
        '{32'sd10,     1'b1, 1'b1, '{1'b0, 11'd0, 1'b0}},
        '{32'sh55555555, 1'b1, 1'b0, '0},
        '{32'shAAAAAAAA, 1'b0, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    pgs_req_if request_bus ();
    pgs_res_if result_bus ();

    previous_greater_search #(
        .MAX_ITEMS(SEQ_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .request(request_bus),
        .result(result_bus)
    );

    logic signed [VALUE_W-1:0] greater_values [SEQ_LIMIT];
    logic [POS_W-1:0]          greater_positions [SEQ_LIMIT];
    int                        stack_depth;
    int                        sequence_length;
    int                        deepest_stack;

    answer_t awaited_answers [$];
    bit      steady;
    int      failures;
    int      items_sent;
    int      answers_checked;
    int      overflow_answers;
    int      quiet_cycles;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic answer_t nearest_greater(input logic signed [VALUE_W-1:0] v,
                                                input logic first);
        answer_t a;
        a = '0;
        if (first)
        begin
            stack_depth     = 0;
            sequence_length = 0;
        end
        if (sequence_length >= SEQ_LIMIT)
        begin
            a.overflow = 1'b1;
            return a;
        end
        while (stack_depth > 0 && greater_values[stack_depth-1] <= v)
            stack_depth--;
        if (stack_depth > 0)
        begin
            a.found    = 1'b1;
            a.position = greater_positions[stack_depth-1];
        end
        sequence_length++;
        if (stack_depth < SEQ_LIMIT)
        begin
            greater_values[stack_depth]    = v;
            greater_positions[stack_depth] = POS_W'(sequence_length);
            stack_depth++;
        end
        if (stack_depth > deepest_stack)
            deepest_stack = stack_depth;
        return a;
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_value(input value_mode_t mode,
                                                            input logic signed [VALUE_W-1:0] prev);
        logic signed [VALUE_W-1:0] v;
        case (mode)
            NEAR_ZERO: v = VALUE_W'(int'($urandom_range(16)) - 8);
            ANY_VALUE: v = $urandom;
            FALLING:   v = prev - VALUE_W'($urandom_range(40)) + 8;
            default:
            begin
                case ($urandom_range(4))
                    0: v = VALUE_MAX;
                    1: v = VALUE_MIN;
                    2: v = '0;
                    3: v = -32'sd1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // hold the item until taken, then predict its answer and idle at random
    task automatic offer_item(input logic signed [VALUE_W-1:0] v, input logic first,
                              input logic typed, input answer_t typed_answer);
        answer_t predicted;
        request_bus.valid             <= 1'b1;
        request_bus.value             <= v;
        request_bus.first_of_sequence <= first;
        @(posedge clk);
        while (!request_bus.ready)
            @(posedge clk);
        predicted = nearest_greater(v, first);
        awaited_answers.insert(awaited_answers.size(), typed ? typed_answer : predicted);
        items_sent++;
        if (!steady)
        begin
            while ($urandom_range(99) < 27)
            begin
                request_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // strictly falling run up to the sequence limit (last item optionally a VALUE_MAX peak), then overflow
    task automatic run_long_sequence(input bit peak_last);
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] w;
        v = VALUE_MAX - VALUE_W'($urandom_range(1000, 1));
        for (int k = 0; k < SEQ_LIMIT + 2; k++)
        begin
            if (peak_last && k == SEQ_LIMIT - 1)
                w = VALUE_MAX;
            else if (k >= SEQ_LIMIT)
                w = $urandom;
            else
                w = v;
            offer_item(w, k == 0, 1'b0, '0);
            v = v - VALUE_W'($urandom_range(1000, 1));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("result item with no request item pending");
                    failures++;
                end
                else
                begin
                    answer_t exp_a;
                    exp_a = awaited_answers.pop_front();
                    answers_checked++;
                    if (result_bus.overflow)
                        overflow_answers++;
                    if (result_bus.found !== exp_a.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_a.found, result_bus.found);
                        failures++;
                    end
                    if (result_bus.position !== exp_a.position)
                    begin
                        $error("position: expected %0d, got %0d",
                               exp_a.position, result_bus.position);
                        failures++;
                    end
                    if (result_bus.overflow !== exp_a.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d",
                               exp_a.overflow, result_bus.overflow);
                        failures++;
                    end
                end
            end
            result_bus.ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_bus.valid && request_bus.ready)
            || (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        value_mode_t               mode;
        logic signed [VALUE_W-1:0] v;
        logic                      first;
        int                        len;
        int                        sent_random;
        bit                        long_done;

        rst_n                         = 1'b0;
        request_bus.valid            <= 1'b0;
        request_bus.value            <= '0;
        request_bus.first_of_sequence <= 1'b0;
        steady                        = 1'b0;
        items_sent                    = 0;
        stack_depth                   = 0;
        sequence_length               = 0;
        deepest_stack                 = 0;
        sent_random                   = 0;
        long_done                     = 1'b0;
        v                             = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_item(DIRECTED[i].value, DIRECTED[i].first, DIRECTED[i].typed,
                       DIRECTED[i].answer);

        while (sent_random < RANDOM_ITEMS)
        begin
            steady = (sent_random >= 20 && sent_random < 60);
            if (sent_random >= 60 && !long_done)
            begin
                run_long_sequence(1'b1);
                long_done = 1'b1;
            end
            len  = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
            mode = value_mode_t'($urandom_range(3));
            for (int k = 0; k < len; k++)
            begin
                first = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
                v     = draw_value(mode, v);
                offer_item(v, first, 1'b0, '0);
                sent_random++;
            end
        end
        steady             = 1'b0;
        request_bus.valid <= 1'b0;

        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d of them overflow",
                 items_sent, answers_checked, overflow_answers);
        $display("deepest candidate stack reached: %0d entries", deepest_stack);
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
